FILE: src/hrhp_pkg.sv
`timescale 1ns / 1ps

package hrhp_pkg;

  // Width of the internal Content-Length accumulator (16 to 64)
  localparam int LENGTH_BITS = 32;
  localparam int ACC_EXT_W   = LENGTH_BITS + 4;

  localparam int CODE_W      = 16;
  localparam int OUT_LEN_W   = 32;
  localparam int SIG_LEN     = 9;
  localparam int LABEL_LEN   = 16;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [CODE_W-1:0] CODE_CONTINUE  = 16'd100;
  localparam logic [CODE_W-1:0] CODE_OK        = 16'd200;
  localparam logic [CODE_W-1:0] CODE_FOUND     = 16'd302;
  localparam logic [CODE_W-1:0] CODE_NOT_FOUND = 16'd404;

  typedef enum logic [1:0] {
    PH_SIG,
    PH_CODE,
    PH_STRIP,
    PH_FIELDS
  } phase_t;

  typedef enum logic [1:0] {
    LE_NONE,
    LE_CR,
    LE_CRLF,
    LE_CRLFCR
  } line_end_t;

  typedef enum logic [2:0] {
    ST_CONTINUE      = 3'd0,
    ST_OK            = 3'd1,
    ST_FOUND         = 3'd2,
    ST_NOT_FOUND     = 3'd3,
    ST_UNHANDLED     = 3'd4,
    ST_UNKNOWN_PROTO = 3'd5,
    ST_MALFORMED     = 3'd6
  } status_t;

  // One result from the parse core toward the output register
  typedef struct packed {
    logic                 emit;
    status_t              status;
    logic [CODE_W-1:0]    code;
    logic [OUT_LEN_W-1:0] length;
    logic                 seen;
  } res_t;

  function automatic logic [7:0] sig_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "H";
      4'd1:    c = "T";
      4'd2:    c = "T";
      4'd3:    c = "P";
      4'd4:    c = "/";
      4'd5:    c = "1";
      4'd6:    c = ".";
      4'd7:    c = "1";
      4'd8:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] label_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      4'd15:   c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/http_response_head_parser_top.sv
`timescale 1ns / 1ps
// HTTP response head parser.
// Input channel: one byte of the response stream per item on in_rx_byte,
// taken when in_valid is high and in_stall is low.
// Result channel: one item per finished response head (out_status,
// out_response_code, out_content_length, out_length_seen), taken when
// out_valid is high and out_stall is low.
// Path: a taken byte is held in the input register; the parse logic
// then updates the state and, when that byte ends a head, ends a 404 or
// unhandled code, or breaks the signature, loads the result register,
// which drives out_valid.
// Throughput: one byte per cycle unless the result register is full and
// stalled, set by the single state update between the two registers.
// Stall: while the result register is full and stalled, the held byte
// waits whether or not it gives a result, and in_stall is high while a
// byte is held; once the result is taken the flow resumes.
// Reset: synchronous, rst_n low clears both registers' valid bits and
// returns the parser to signature matching. No clearing pass.
module http_response_head_parser_top
  import hrhp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [CODE_W-1:0]    out_response_code,
  output logic [OUT_LEN_W-1:0] out_content_length,
  output logic                 out_length_seen
);

  logic       go;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       step;
  res_t       res;

  // a held byte is parsed only when its result has a place to go
  assign step = byte_valid & go;

  hrhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .go         (go),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  hrhp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_data),
    .res     (res)
  );

  hrhp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (step),
    .res                (res),
    .go                 (go),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_response_code  (out_response_code),
    .out_content_length (out_content_length),
    .out_length_seen    (out_length_seen)
  );

endmodule

FILE: src/hrhp_in_stage.sv
`timescale 1ns / 1ps

module hrhp_in_stage
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       go,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // held item drains when the result side has room
  assign in_stall  = valid_r & ~go;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

FILE: src/hrhp_core.sv
`timescale 1ns / 1ps

module hrhp_core
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  phase_t                 phase_r,    phase_nxt;
  logic [3:0]             sig_idx_r,  sig_idx_nxt;
  logic [CODE_W-1:0]      code_r,     code_nxt;
  line_end_t              le_r,       le_nxt;
  logic [4:0]             lbl_idx_r,  lbl_idx_nxt;
  logic [LENGTH_BITS-1:0] len_r,      len_nxt;
  logic                   found_r,    found_nxt;
  logic                   done_r,     done_nxt;
  logic                   bad_r,      bad_nxt;

  logic                          is_digit;
  logic [3:0]                    dval;
  logic [CODE_W-1:0]             code_step;
  logic [ACC_EXT_W-1:0]          len_ext;
  logic                          len_ovf;
  logic                          hdr_end;
  line_end_t                     le_upd;
  logic [4:0]                    lbl_inc;
  logic [LENGTH_BITS+OUT_LEN_W-1:0] len_wide;

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign dval      = 4'(rx_byte - CH_ZERO);
  assign code_step = (code_r << 3) + (code_r << 1) + CODE_W'(dval);
  assign len_ext   = ({4'b0, len_r} << 3) + ({4'b0, len_r} << 1) + ACC_EXT_W'(dval);
  assign len_ovf   = |len_ext[ACC_EXT_W-1:LENGTH_BITS];
  assign lbl_inc   = lbl_idx_r + 5'd1;

  // CR LF CR LF tracker
  always_comb begin
    hdr_end = 1'b0;
    le_upd  = LE_NONE;
    if (rx_byte == CH_CR) begin
      le_upd = (le_r == LE_CRLF) ? LE_CRLFCR : LE_CR;
    end else if (rx_byte == CH_LF) begin
      if (le_r == LE_CR) begin
        le_upd = LE_CRLF;
      end else if (le_r == LE_CRLFCR) begin
        le_upd  = le_r;
        hdr_end = 1'b1;
      end
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    sig_idx_nxt = sig_idx_r;
    code_nxt    = code_r;
    le_nxt      = le_r;
    lbl_idx_nxt = lbl_idx_r;
    len_nxt     = len_r;
    found_nxt   = found_r;
    done_nxt    = done_r;
    bad_nxt     = bad_r;
    len_wide    = '0;

    res.emit   = 1'b0;
    res.status = ST_CONTINUE;
    res.code   = code_r;
    res.length = '0;
    res.seen   = 1'b0;

    if (step) begin
      case (phase_r)
        PH_CODE: begin
          if (is_digit) begin
            code_nxt = code_step;
          end else if (code_r == CODE_CONTINUE) begin
            phase_nxt = PH_STRIP;
          end else if (code_r == CODE_OK || code_r == CODE_FOUND) begin
            phase_nxt = PH_FIELDS;
          end else if (code_r == CODE_NOT_FOUND) begin
            res.emit   = 1'b1;
            res.status = ST_NOT_FOUND;
          end else begin
            res.emit   = 1'b1;
            res.status = ST_UNHANDLED;
          end
        end

        PH_STRIP: begin
          le_nxt = le_upd;
          if (hdr_end) begin
            res.emit   = 1'b1;
            res.status = ST_CONTINUE;
          end
        end

        PH_FIELDS: begin
          // label search, then value capture up to CR
          if (!found_r) begin
            if (rx_byte == label_char(lbl_idx_r[3:0])) begin
              lbl_idx_nxt = lbl_inc;
            end else begin
              lbl_idx_nxt = (rx_byte == label_char(4'd0)) ? 5'd1 : 5'd0;
            end
            if (lbl_idx_nxt == 5'(LABEL_LEN)) begin
              found_nxt = 1'b1;
            end
          end else if (!done_r) begin
            if (rx_byte == CH_CR) begin
              done_nxt = 1'b1;
            end else if (is_digit) begin
              if (!bad_r) begin
                if (len_ovf) begin
                  bad_nxt = 1'b1;
                end else begin
                  len_nxt = len_ext[LENGTH_BITS-1:0];
                end
              end
            end else begin
              bad_nxt = 1'b1;
            end
          end

          le_nxt = le_upd;
          if (hdr_end) begin
            res.emit = 1'b1;
            res.seen = found_nxt;
            if (bad_nxt) begin
              res.status = ST_MALFORMED;
            end else begin
              res.status = (code_r == CODE_OK) ? ST_OK : ST_FOUND;
              if (found_nxt) begin
                len_wide   = {{OUT_LEN_W{1'b0}}, len_nxt};
                res.length = len_wide[OUT_LEN_W-1:0];
              end
            end
          end
        end

        default: begin
          if (sig_idx_r >= 4'(SIG_LEN) || rx_byte != sig_char(sig_idx_r)) begin
            res.emit   = 1'b1;
            res.status = ST_UNKNOWN_PROTO;
            res.code   = '0;
          end else begin
            sig_idx_nxt = sig_idx_r + 4'd1;
            if (sig_idx_nxt == 4'(SIG_LEN)) begin
              phase_nxt = PH_CODE;
              code_nxt  = '0;
            end
          end
        end
      endcase

      // every result returns the parser to idle
      if (res.emit) begin
        phase_nxt   = PH_SIG;
        sig_idx_nxt = '0;
        code_nxt    = '0;
        le_nxt      = LE_NONE;
        lbl_idx_nxt = '0;
        len_nxt     = '0;
        found_nxt   = 1'b0;
        done_nxt    = 1'b0;
        bad_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG;
      sig_idx_r <= '0;
      code_r    <= '0;
      le_r      <= LE_NONE;
      lbl_idx_r <= '0;
      len_r     <= '0;
      found_r   <= 1'b0;
      done_r    <= 1'b0;
      bad_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      sig_idx_r <= sig_idx_nxt;
      code_r    <= code_nxt;
      le_r      <= le_nxt;
      lbl_idx_r <= lbl_idx_nxt;
      len_r     <= len_nxt;
      found_r   <= found_nxt;
      done_r    <= done_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // while matching the signature nothing else has been collected
  a_sig_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SIG |-> (code_r == '0 && len_r == '0 && lbl_idx_r == '0))
    else $error("state not cleared while matching signature");

  // value flags only move once the label is found
  a_flags_after_label: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r || bad_r || len_r != '0) |-> found_r)
    else $error("value flags set before label found");

  a_sig_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sig_idx_r <= 4'(SIG_LEN))
    else $error("signature index out of range");

  a_label_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    lbl_idx_r <= 5'(LABEL_LEN) && (phase_r == PH_FIELDS || lbl_idx_r == '0))
    else $error("label index out of range");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.emit && res.status == ST_UNKNOWN_PROTO) |-> (res.code == '0 && !res.seen))
    else $error("unknown protocol result carries a code");

endmodule

FILE: src/hrhp_out_stage.sv
`timescale 1ns / 1ps

module hrhp_out_stage
  import hrhp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  res_t                 res,
  output logic                 go,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [CODE_W-1:0]    out_response_code,
  output logic [OUT_LEN_W-1:0] out_content_length,
  output logic                 out_length_seen
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 load;
  status_t              status_r;
  logic [CODE_W-1:0]    code_r;
  logic [OUT_LEN_W-1:0] length_r;
  logic                 seen_r;

  // register is free when empty or being taken this cycle
  assign go        = ~valid_r | ~out_stall;
  assign load      = step & res.emit;
  assign valid_nxt = go ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res.status;
      code_r   <= res.code;
      length_r <= res.length;
      seen_r   <= res.seen;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = 3'(status_r);
  assign out_response_code  = code_r;
  assign out_content_length = length_r;
  assign out_length_seen    = seen_r;

endmodule
